[sv/pps_pkg.sv]
// Shared types and constants for the priority process scheduler.
package pps_pkg;

    localparam int PID_W   = 8;
    localparam int BURST_W = 10;
    localparam int PRIO_W  = 4;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] remaining;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

endpackage

[sv/pps_entry_mem.sv]
// Process table memory with one write port and one registered read port.
module pps_entry_mem
    import pps_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/pps_ctrl.sv]
// Scheduler sequencer: arrivals, priority scan, run step and table compaction.
module pps_ctrl
    import pps_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [PID_W-1:0]   s_new_pid,
    input  logic [BURST_W-1:0] s_new_burst,
    input  logic [PRIO_W-1:0]  s_new_priority,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PID_W-1:0]   m_running_pid,
    output logic               m_finished,
    output logic               m_arrival_rejected,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output entry_t             mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    input  entry_t             mem_rdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_EXEC,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               preempt_reg, preempt_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               locked_reg, locked_next;
    logic [AW-1:0]      run_slot_reg, run_slot_next;

    logic               req_type_reg, req_type_next;
    entry_t             req_reg, req_next;

    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic [CW-1:0]      rd_end_reg, rd_end_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic               first_reg, first_next;
    entry_t             best_reg, best_next;
    logic [AW-1:0]      best_slot_reg, best_slot_next;
    logic [CW-1:0]      sh_idx_reg, sh_idx_next;

    logic [PID_W-1:0]   res_pid_reg, res_pid_next;
    logic               res_fin_reg, res_fin_next;
    logic               res_rej_reg, res_rej_next;

    logic               m_valid_reg, m_valid_next;
    logic [PID_W-1:0]   m_pid_reg, m_pid_next;
    logic               m_fin_reg, m_fin_next;
    logic               m_rej_reg, m_rej_next;

    logic [BURST_W-1:0] rem_dec;
    logic [CW-1:0]      best_slot_ext;
    logic [CW-1:0]      run_slot_ext;
    logic [CW-1:0]      sh_idx_inc;

    assign rem_dec       = (best_reg.remaining != '0) ? best_reg.remaining - 1'b1
                                                      : best_reg.remaining;
    assign best_slot_ext = CW'(best_slot_reg);
    assign run_slot_ext  = CW'(run_slot_reg);
    assign sh_idx_inc    = sh_idx_reg + 1'b1;

    always_comb begin
        state_next     = state_reg;
        preempt_next   = preempt_reg;
        count_next     = count_reg;
        locked_next    = locked_reg;
        run_slot_next  = run_slot_reg;
        req_type_next  = req_type_reg;
        req_next       = req_reg;
        rd_idx_next    = rd_idx_reg;
        rd_end_next    = rd_end_reg;
        pend_vld_next  = 1'b0;
        pend_idx_next  = pend_idx_reg;
        first_next     = first_reg;
        best_next      = best_reg;
        best_slot_next = best_slot_reg;
        sh_idx_next    = sh_idx_reg;
        res_pid_next   = res_pid_reg;
        res_fin_next   = res_fin_reg;
        res_rej_next   = res_rej_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_pid_next     = m_pid_reg;
        m_fin_next     = m_fin_reg;
        m_rej_next     = m_rej_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = req_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        if (cfg_wr_en) begin
            preempt_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_type_next      = s_req_type;
                    req_next.pid       = s_new_pid;
                    req_next.remaining = s_new_burst;
                    req_next.prio      = s_new_priority;
                    state_next         = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                res_pid_next = '0;
                res_fin_next = 1'b0;
                res_rej_next = 1'b0;
                if (req_type_reg == REQ_ARRIVAL) begin
                    if (count_reg == CW'(DEPTH) || req_reg.remaining == '0) begin
                        res_rej_next = 1'b1;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ST_DONE;
                end else if (count_reg == '0) begin
                    locked_next = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    if (locked_reg && !preempt_reg && run_slot_ext < count_reg) begin
                        rd_idx_next = run_slot_ext;
                        rd_end_next = run_slot_ext + 1'b1;
                    end else begin
                        rd_idx_next = '0;
                        rd_end_next = count_reg;
                    end
                    first_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_idx_reg < rd_end_reg) begin
                    mem_re        = 1'b1;
                    mem_raddr     = rd_idx_reg[AW-1:0];
                    pend_vld_next = 1'b1;
                    pend_idx_next = rd_idx_reg[AW-1:0];
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end
                if (pend_vld_reg) begin
                    if (first_reg || mem_rdata.prio < best_reg.prio) begin
                        best_next      = mem_rdata;
                        best_slot_next = pend_idx_reg;
                    end
                    first_next = 1'b0;
                end
                if (rd_idx_reg == rd_end_reg && !pend_vld_reg) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_pid_next = best_reg.pid;
                if (rem_dec == '0) begin
                    res_fin_next  = 1'b1;
                    locked_next   = 1'b0;
                    run_slot_next = '0;
                    sh_idx_next   = best_slot_ext;
                    if (best_slot_ext + 1'b1 < count_reg) begin
                        state_next = ST_SH_RD;
                    end else begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_DONE;
                    end
                end else begin
                    mem_we              = 1'b1;
                    mem_waddr           = best_slot_reg;
                    mem_wdata           = best_reg;
                    mem_wdata.remaining = rem_dec;
                    locked_next         = !preempt_reg;
                    if (!preempt_reg) begin
                        run_slot_next = best_slot_reg;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_SH_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = sh_idx_inc[AW-1:0];
                state_next = ST_SH_WR;
            end
            ST_SH_WR: begin
                mem_we      = 1'b1;
                mem_waddr   = sh_idx_reg[AW-1:0];
                mem_wdata   = mem_rdata;
                sh_idx_next = sh_idx_inc;
                if (sh_idx_inc + 1'b1 < count_reg) begin
                    state_next = ST_SH_RD;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pid_next   = res_pid_reg;
                    m_fin_next   = res_fin_reg;
                    m_rej_next   = res_rej_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            preempt_reg  <= 1'b0;
            count_reg    <= '0;
            locked_reg   <= 1'b0;
            run_slot_reg <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            preempt_reg  <= preempt_next;
            count_reg    <= count_next;
            locked_reg   <= locked_next;
            run_slot_reg <= run_slot_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        req_type_reg  <= req_type_next;
        req_reg       <= req_next;
        rd_idx_reg    <= rd_idx_next;
        rd_end_reg    <= rd_end_next;
        pend_idx_reg  <= pend_idx_next;
        first_reg     <= first_next;
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        sh_idx_reg    <= sh_idx_next;
        res_pid_reg   <= res_pid_next;
        res_fin_reg   <= res_fin_next;
        res_rej_reg   <= res_rej_next;
        m_pid_reg     <= m_pid_next;
        m_fin_reg     <= m_fin_next;
        m_rej_reg     <= m_rej_next;
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_running_pid      = m_pid_reg;
    assign m_finished         = m_fin_reg;
    assign m_arrival_rejected = m_rej_reg;

endmodule

[sv/priority_process_scheduler_top.sv]
// Top level of the priority process scheduler: process table memory and sequencer.
// An arrival item passes the dispatch and done states to the output register before the next is taken.
// For a table of N entries, a tick item's run time is set by the one-entry-per-cycle priority scan
// over the table memory; a locked process reads one entry instead of N.
// When a process finishes, compaction moves each later entry down one slot with a read and a write.
// Reset clears the entry count, the lock and the mode; the table memory itself is not cleared.
module priority_process_scheduler_top
    import pps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [PID_W-1:0]   s_new_pid,
    input  logic [BURST_W-1:0] s_new_burst,
    input  logic [PRIO_W-1:0]  s_new_priority,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PID_W-1:0]   m_running_pid,
    output logic               m_finished,
    output logic               m_arrival_rejected
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    pps_entry_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pps_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_new_pid          (s_new_pid),
        .s_new_burst        (s_new_burst),
        .s_new_priority     (s_new_priority),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_running_pid      (m_running_pid),
        .m_finished         (m_finished),
        .m_arrival_rejected (m_arrival_rejected),
        .mem_we             (mem_we),
        .mem_waddr          (mem_waddr),
        .mem_wdata          (mem_wdata),
        .mem_re             (mem_re),
        .mem_raddr          (mem_raddr),
        .mem_rdata          (mem_rdata)
    );

endmodule

[sv/pps_checker.sv]
// Port-level checker for the priority process scheduler and its bind statement.
module pps_checker
    import pps_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [PID_W-1:0]   m_running_pid,
    input logic               m_finished,
    input logic               m_arrival_rejected
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_running_pid)
                                && $stable(m_finished) && $stable(m_arrival_rejected))
        else $error("Stalled result item changed.");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("A second item was taken while one was in progress.");

    a_reject_is_arrival: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_arrival_rejected |-> m_running_pid == '0 && !m_finished)
        else $error("Rejected arrival reports a running process.");

endmodule

bind priority_process_scheduler_top pps_checker u_pps_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_running_pid      (m_running_pid),
    .m_finished         (m_finished),
    .m_arrival_rejected (m_arrival_rejected)
);

[verif/tb_top.sv]
// Self-checking testbench for the priority process scheduler, with its own scheduling predictor.
module tb_top
    import pps_pkg::*;
();

    localparam int QDEPTH      = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int CHUNKS      = 6;
    localparam int CHUNK_ITEMS = 62;

    typedef struct packed {
        logic               req;
        logic [PID_W-1:0]   pid;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } sched_item_t;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic             finished;
        logic             rejected;
    } sched_result_t;

    typedef enum {KEEP_MODE, SET_COOP, SET_PREEMPT} mode_action_t;

    typedef struct {
        int            reps;
        mode_action_t  mode;
        sched_item_t   item;
        bit            typed;
        sched_result_t result;
    } directed_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic [PID_W-1:0]   s_new_pid;
    logic [BURST_W-1:0] s_new_burst;
    logic [PRIO_W-1:0]  s_new_priority;
    logic               m_valid;
    logic               m_ready;
    logic [PID_W-1:0]   m_running_pid;
    logic               m_finished;
    logic               m_arrival_rejected;

    sched_result_t expected_results [$];
    directed_row_t directed_rows [$];

    logic [PID_W-1:0]   ready_pid  [QDEPTH];
    logic [BURST_W-1:0] ready_left [QDEPTH];
    logic [PRIO_W-1:0]  ready_prio [QDEPTH];
    int                 ready_count = 0;
    bit                 run_locked  = 1'b0;
    int                 locked_slot = 0;
    bit                 preempt_mode = 1'b0;

    int send_idle_pct  = 29;
    int recv_idle_pct  = 85;
    int mismatch_count = 0;
    int hold_left      = 0;
    bit hold_pending   = 1'b0;

    priority_process_scheduler_top #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_new_pid         (s_new_pid),
        .s_new_burst       (s_new_burst),
        .s_new_priority    (s_new_priority),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_running_pid     (m_running_pid),
        .m_finished        (m_finished),
        .m_arrival_rejected(m_arrival_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic sched_result_t schedule_step(input sched_item_t it);
        sched_result_t r;
        int slot;
        int s;
        r = '0;
        if (it.req == REQ_ARRIVAL) begin
            if (ready_count >= QDEPTH || it.burst == '0) begin
                r.rejected = 1'b1;
            end else begin
                ready_pid[ready_count]  = it.pid;
                ready_left[ready_count] = it.burst;
                ready_prio[ready_count] = it.prio;
                ready_count++;
            end
        end else if (ready_count == 0) begin
            run_locked = 1'b0;
        end else begin
            if (preempt_mode)
                run_locked = 1'b0;
            if (run_locked && locked_slot < ready_count) begin
                slot = locked_slot;
            end else begin
                slot = 0;
                for (s = 1; s < ready_count; s++)
                    if (ready_prio[s] < ready_prio[slot])
                        slot = s;
            end
            r.pid = ready_pid[slot];
            if (ready_left[slot] != '0)
                ready_left[slot] = ready_left[slot] - 1'b1;
            if (ready_left[slot] == '0) begin
                r.finished = 1'b1;
                for (s = slot; s + 1 < ready_count; s++) begin
                    ready_pid[s]  = ready_pid[s + 1];
                    ready_left[s] = ready_left[s + 1];
                    ready_prio[s] = ready_prio[s + 1];
                end
                ready_count--;
                run_locked  = 1'b0;
                locked_slot = 0;
            end else if (!preempt_mode) begin
                run_locked  = 1'b1;
                locked_slot = slot;
            end
        end
        return r;
    endfunction

    task automatic add_row(input int reps, input mode_action_t mode, input logic req,
                           input int pid, input int burst, input int prio, input bit typed,
                           input int want_pid, input bit want_fin, input bit want_rej);
        directed_row_t row;
        row.reps            = reps;
        row.mode            = mode;
        row.item.req        = req;
        row.item.pid        = PID_W'(pid);
        row.item.burst      = BURST_W'(burst);
        row.item.prio       = PRIO_W'(prio);
        row.typed           = typed;
        row.result.pid      = PID_W'(want_pid);
        row.result.finished = want_fin;
        row.result.rejected = want_rej;
        directed_rows.push_back(row);
    endtask

    task automatic issue_item(input sched_item_t it, input bit typed,
                              input sched_result_t given);
        sched_result_t predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_req_type     <= it.req;
        s_new_pid      <= it.pid;
        s_new_burst    <= it.burst;
        s_new_priority <= it.prio;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = schedule_step(it);
        expected_results.push_back(typed ? given : predicted);
    endtask

    task automatic wait_for_results();
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_mode(input bit preempt);
        s_valid <= 1'b0;
        wait_for_results();
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= preempt;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        preempt_mode = preempt;
    endtask

    always @(posedge aclk) begin : result_monitor
        sched_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result item: pid %0d finished %0d rejected %0d",
                             m_running_pid, m_finished, m_arrival_rejected);
            end else begin
                want = expected_results.pop_front();
                if (m_running_pid !== want.pid || m_finished !== want.finished ||
                    m_arrival_rejected !== want.rejected) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected pid %0d fin %0d rej %0d, got %0d %0d %0d",
                                 want.pid, want.finished, want.rejected,
                                 m_running_pid, m_finished, m_arrival_rejected);
                end
            end
        end
        if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
        end
        if (!aresetn || hold_left > 0) begin
            m_ready <= 1'b0;
            if (hold_left > 0)
                hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        sched_item_t   it;
        sched_result_t unused;
        int            chunk;
        int            n;
        int            k;
        int            r;
        int            tick_pct;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = 1'b0;
        s_valid        = 1'b0;
        s_req_type     = REQ_ARRIVAL;
        s_new_pid      = '0;
        s_new_burst    = '0;
        s_new_priority = '0;
        unused         = '0;

        //      reps mode         req          pid  burst prio typed pid fin rej
        add_row(1,  KEEP_MODE,   REQ_TICK,    0,   0,    0,   1,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 0,   0,    0,   1,    0,  0,  1);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 255, 1023, 15,  1,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 0,   1,    0,   1,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_TICK,    0,   0,    0,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 7,   2,    3,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 7,   1,    3,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_TICK,    0,   0,    0,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 9,   1,    0,   0,    0,  0,  0);
        add_row(2,  KEEP_MODE,   REQ_TICK,    0,   0,    0,   0,    0,  0,  0);
        add_row(1,  SET_PREEMPT, REQ_ARRIVAL, 20,  3,    5,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_TICK,    0,   0,    0,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 21,  1,    1,   0,    0,  0,  0);
        add_row(2,  KEEP_MODE,   REQ_TICK,    0,   0,    0,   0,    0,  0,  0);
        add_row(1,  SET_COOP,    REQ_TICK,    0,   0,    0,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 30,  2,    0,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_TICK,    0,   0,    0,   0,    0,  0,  0);
        add_row(16, KEEP_MODE,   REQ_ARRIVAL, 100, 2,    8,   0,    0,  0,  0);
        add_row(1,  KEEP_MODE,   REQ_ARRIVAL, 101, 5,    1,   1,    0,  0,  1);
        add_row(40, KEEP_MODE,   REQ_TICK,    0,   0,    0,   0,    0,  0,  0);
        add_row(6,  SET_PREEMPT, REQ_TICK,    0,   0,    0,   0,    0,  0,  0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].mode != KEEP_MODE)
                set_mode(directed_rows[i].mode == SET_PREEMPT);
            for (k = 0; k < directed_rows[i].reps; k++)
                issue_item(directed_rows[i].item, directed_rows[i].typed,
                           directed_rows[i].result);
        end

        for (chunk = 0; chunk < CHUNKS; chunk++) begin
            send_idle_pct = (chunk < 2) ? 29 : (chunk < 4) ? 85 : 0;
            recv_idle_pct = (chunk < 2) ? 85 : (chunk < 4) ? 29 : 0;
            set_mode(chunk % 2 == 0);
            tick_pct = $urandom_range(80, 30);
            for (n = 0; n < CHUNK_ITEMS; n++) begin
                if (chunk == 4 && n == 10)
                    hold_pending = 1'b1;
                if (chunk == 3 && n == 40) begin
                    s_valid <= 1'b0;
                    wait_for_results();
                end
                it.pid  = PID_W'($urandom_range(255));
                it.prio = PRIO_W'($urandom_range(15));
                r = $urandom_range(99);
                if (r < 5) begin
                    it.burst = '0;
                end else if (r < 7) begin
                    it.burst = BURST_W'($urandom_range(1023, 1));
                    it.prio  = PRIO_W'($urandom_range(15, 12));
                end else begin
                    it.burst = BURST_W'($urandom_range(6, 1));
                end
                it.req = ($urandom_range(99) < tick_pct) ? REQ_TICK : REQ_ARRIVAL;
                issue_item(it, 1'b0, unused);
            end
        end

        s_valid <= 1'b0;
        wait_for_results();
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
